/* hw/rtl/ldas_pkg.sv */
// Shared constants, codes and types of the linear-plus-delta angle sampler.
package ldas_pkg;

  // Fixed-point format: signed Q2.30 for cosines, densities and probabilities.
  localparam int FracBits = 30;
  localparam logic signed [31:0] One = 32'sh4000_0000;

  // Default depth of the queue between the front and the back.
  localparam int QueueDepth = 2;

  // Width of the fraction handed to the root pipeline; it can reach 2^32.
  localparam int FracW = 33;
  // The radicand is the fraction shifted up by 2*FracBits-32 bits.
  localparam int RadShift = 2 * FracBits - 32;
  localparam int RootW = (FracW + RadShift + 1) / 2;
  localparam int RadW = 2 * RootW;
  localparam int RemW = RootW + 2;

  // The sample scale sqrt(2/a) stays below 2^46 for every nonzero intercept.
  localparam int ScaleW = 46;
  localparam int ScaleLoW = ScaleW / 2;

  typedef logic [1:0] op_t;
  localparam op_t OpDensity    = 2'd0;
  localparam op_t OpCumulative = 2'd1;
  localparam op_t OpSample     = 2'd2;
  localparam op_t OpUnused     = 2'd3;

  typedef enum logic [1:0] {
    DRV_IDLE,
    DRV_DIV,
    DRV_ROOT
  } drv_state_t;

  // Law coefficients derived from the mean cosine.
  typedef struct packed {
    logic signed [31:0] intercept;
    logic signed [31:0] slope;
    logic signed [31:0] delta;
    logic               plus_pole;
    logic [ScaleW-1:0]  scale;
    logic               scale_sat;
    logic               busy;
  } law_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    op_t                op;
    logic signed [31:0] x;
    logic [FracW-1:0]   frac;
    logic               pole_hit;
    logic               delta_hit;
  } item_t;

endpackage

/* hw/rtl/ldas_req_if.sv */
// Request channel: opcode, evaluation cosine and uniform fraction.
interface ldas_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] cosine_point;
  logic [31:0]        uniform_fraction;

  modport source (output valid, opcode, cosine_point, uniform_fraction, input ready);
  modport sink (input valid, opcode, cosine_point, uniform_fraction, output ready);
endinterface

/* hw/rtl/ldas_rsp_if.sv */
// Response channel: result value and infinity flag.
interface ldas_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               is_infinite;

  modport source (output valid, result_value, is_infinite, input ready);
  modport sink (input valid, result_value, is_infinite, output ready);
endinterface

/* hw/rtl/ldas_derive.sv */
// Derivation of the law coefficients and the sample scale from the mean cosine.
module ldas_derive (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic signed [31:0] cfg_data,
  output ldas_pkg::law_t     law
);

  localparam int DivSteps = 3 * ldas_pkg::FracBits + 2;
  localparam int QuoW = DivSteps;
  localparam int SqRemW = ldas_pkg::ScaleW + 2;
  localparam int CntW = $clog2(DivSteps);
  localparam logic signed [33:0] One34 = 34'(ldas_pkg::One);
  localparam logic signed [33:0] ResetA34 = (34'sd3 * One34) >>> 2;
  localparam logic signed [31:0] ResetIntercept = ResetA34[31:0];
  localparam logic signed [31:0] ResetDelta = -(ldas_pkg::One >>> 1);

  ldas_pkg::drv_state_t state, state_next;
  logic [CntW-1:0]       cnt;
  logic signed [31:0]    intercept, slope, delta;
  logic                  plus_pole, scale_sat;
  logic [30:0]           div_rem;
  logic [QuoW-1:0]       quo;
  logic [SqRemW-1:0]     sq_rem;
  logic [ldas_pkg::ScaleW-1:0] root;

  // Coefficients of a newly written mean cosine.
  logic signed [31:0] m_c;
  logic signed [33:0] mx, t3, a34, u34, d34;
  logic signed [31:0] a_n, s_n, d_n;
  logic               plus_n;

  always_comb begin
    if (cfg_data > ldas_pkg::One) begin
      m_c = ldas_pkg::One;
    end else if (cfg_data < -ldas_pkg::One) begin
      m_c = -ldas_pkg::One;
    end else begin
      m_c = cfg_data;
    end
    mx = {{2{m_c[31]}}, m_c};
    u34 = 34'sd3 * mx - One34;
    if (!m_c[31]) begin
      plus_n = 1'b1;
      t3 = 34'sd3 * (One34 - mx);
      a34 = t3 >>> 2;
      d34 = u34[33] ? -((-u34) >>> 1) : (u34 >>> 1);
      a_n = a34[31:0];
      s_n = a34[31:0];
    end else begin
      plus_n = 1'b0;
      t3 = 34'sd3 * (One34 + mx);
      a34 = t3 >>> 2;
      d34 = One34 - (a34 <<< 1);
      a_n = a34[31:0];
      s_n = -a34[31:0];
    end
    d_n = d34[31:0];
  end

  // Restoring divide step for 2^91 / a and a two-bit step of the square root.
  logic [31:0]       div_sh;
  logic              div_ge;
  logic [SqRemW+1:0] sq_sh, sq_trial;
  logic              sq_ge;

  always_comb begin
    div_sh = {div_rem, (cnt == CntW'(DivSteps - 1))};
    div_ge = div_sh >= 32'(intercept);
    sq_sh = {sq_rem, quo[QuoW-1 -: 2]};
    sq_trial = {2'b00, root, 2'b01};
    sq_ge = sq_sh >= sq_trial;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ldas_pkg::DRV_IDLE: begin
        if (cfg_we && a_n != 32'sd0) begin
          state_next = ldas_pkg::DRV_DIV;
        end
      end
      ldas_pkg::DRV_DIV: begin
        if (cfg_we) begin
          state_next = (a_n != 32'sd0) ? ldas_pkg::DRV_DIV : ldas_pkg::DRV_IDLE;
        end else if (cnt == '0) begin
          state_next = ldas_pkg::DRV_ROOT;
        end
      end
      ldas_pkg::DRV_ROOT: begin
        if (cfg_we) begin
          state_next = (a_n != 32'sd0) ? ldas_pkg::DRV_DIV : ldas_pkg::DRV_IDLE;
        end else if (cnt == '0) begin
          state_next = ldas_pkg::DRV_IDLE;
        end
      end
      default: state_next = ldas_pkg::DRV_IDLE;
    endcase
  end

  always_comb begin
    law.intercept = intercept;
    law.slope = slope;
    law.delta = delta;
    law.plus_pole = plus_pole;
    law.scale = root;
    law.scale_sat = scale_sat;
    law.busy = (state != ldas_pkg::DRV_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ldas_pkg::DRV_DIV;
      cnt <= CntW'(DivSteps - 1);
      intercept <= ResetIntercept;
      slope <= ResetIntercept;
      delta <= ResetDelta;
      plus_pole <= 1'b1;
      scale_sat <= 1'b0;
      div_rem <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        intercept <= a_n;
        slope <= s_n;
        delta <= d_n;
        plus_pole <= plus_n;
        scale_sat <= (a_n == 32'sd0);
        cnt <= CntW'(DivSteps - 1);
        div_rem <= '0;
      end else if (state == ldas_pkg::DRV_DIV) begin
        div_rem <= div_ge ? 31'(div_sh - 32'(intercept)) : div_sh[30:0];
        cnt <= (cnt == '0) ? CntW'(ldas_pkg::ScaleW - 1) : cnt - 1'b1;
      end else if (state == ldas_pkg::DRV_ROOT) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ldas_pkg::DRV_DIV) begin
      quo <= {quo[QuoW-2:0], div_ge};
      sq_rem <= '0;
      root <= '0;
    end else if (state == ldas_pkg::DRV_ROOT) begin
      quo <= {quo[QuoW-3:0], 2'b00};
      sq_rem <= sq_ge ? SqRemW'(sq_sh - sq_trial) : sq_sh[SqRemW-1:0];
      root <= {root[ldas_pkg::ScaleW-2:0], sq_ge};
    end
  end

  a_sat_zero: assert property (@(posedge clk) disable iff (rst)
    !law.busy |-> (law.scale_sat == (law.intercept == 32'sd0)))
    else $error("scale saturation disagrees with the intercept");

  a_slope_sign: assert property (@(posedge clk) disable iff (rst)
    !law.busy |-> (law.plus_pole ? (law.slope == law.intercept)
                                 : (law.slope == -law.intercept)))
    else $error("slope does not match the pole side");

endmodule

/* hw/rtl/ldas_front.sv */
// Front end: accepts requests, classifies them and queues them for the back end.
module ldas_front #(
  parameter int DEPTH = ldas_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  ldas_req_if.sink        req,
  input  ldas_pkg::law_t  law,
  output ldas_pkg::item_t head,
  output logic            head_valid,
  input  logic            pop
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic signed [33:0] One34 = 34'(ldas_pkg::One);

  ldas_pkg::item_t slots [DEPTH];
  ldas_pkg::item_t item;
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic signed [31:0] pole;
  logic signed [33:0] dx, thr_plus;
  logic [33:0]     u34;

  assign req.ready = (count != CntW'(DEPTH)) && !law.busy;
  assign push = req.valid && req.ready;

  always_comb begin
    pole = law.plus_pole ? ldas_pkg::One : -ldas_pkg::One;
    dx = {{2{law.delta[31]}}, law.delta};
    thr_plus = (One34 - dx) <<< 2;
    u34 = {2'b00, req.uniform_fraction};
    item.op = req.opcode;
    item.x = req.cosine_point;
    item.pole_hit = (req.cosine_point == pole);
    if (law.plus_pole) begin
      item.frac = {1'b0, req.uniform_fraction};
      item.delta_hit = u34 > thr_plus;
    end else begin
      item.frac = {1'b1, 32'd0} - {1'b0, req.uniform_fraction};
      item.delta_hit = !law.delta[31] && (u34 <= {law.delta[31:0], 2'b00});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

  assign head = slots[rd_ptr];
  assign head_valid = (count != '0);

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (count == CntW'(DEPTH)) |-> !req.ready)
    else $error("queue accepts a beat while full");

endmodule

/* hw/rtl/ldas_back.sv */
// Back end: square-root pipeline, products and result selection.
module ldas_back (
  input  logic            clk,
  input  logic            rst,
  input  ldas_pkg::law_t  law,
  input  ldas_pkg::item_t head,
  input  logic            head_valid,
  output logic            pop,
  ldas_rsp_if.source      rsp
);

  localparam int RootW = ldas_pkg::RootW;
  localparam int RadW = ldas_pkg::RadW;
  localparam int RemW = ldas_pkg::RemW;
  localparam int ScaleW = ldas_pkg::ScaleW;
  localparam int ScaleLoW = ldas_pkg::ScaleLoW;
  localparam int ScaleHiW = ScaleW - ScaleLoW;
  localparam int PrW = ScaleHiW + RootW;
  localparam int SumW = ScaleW + RootW + 1;
  localparam logic signed [33:0] One34 = 34'(ldas_pkg::One);

  typedef struct packed {
    logic            vld;
    ldas_pkg::item_t tag;
    logic [RadW-1:0] rad;
    logic [RemW-1:0] rem;
    logic [RootW-1:0] root;
  } sq_t;

  typedef struct packed {
    logic            vld;
    ldas_pkg::item_t tag;
    logic [RootW-1:0] root;
    logic [63:0]     xx_p;
    logic [61:0]     pa;
    logic            pa_neg;
    logic [61:0]     ps;
    logic            ps_neg;
    logic [PrW-1:0]  sc_lo;
    logic [PrW-1:0]  sc_hi;
  } t1_t;

  typedef struct packed {
    logic               vld;
    ldas_pkg::item_t    tag;
    logic signed [33:0] pdf;
    logic signed [33:0] c1;
    logic [62:0]        pst;
    logic               pst_neg;
    logic signed [31:0] smp;
  } t2_t;

  function automatic sq_t sq_step(sq_t s);
    sq_t r;
    logic [RemW+1:0] rs;
    logic [RemW+1:0] trial;
    r = s;
    rs = {s.rem, s.rad[RadW-1 -: 2]};
    trial = {{(RemW - RootW){1'b0}}, s.root, 2'b01};
    r.rad = {s.rad[RadW-3:0], 2'b00};
    if (rs >= trial) begin
      r.rem = RemW'(rs - trial);
      r.root = {s.root[RootW-2:0], 1'b1};
    end else begin
      r.rem = rs[RemW-1:0];
      r.root = {s.root[RootW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic adv;
  sq_t  stg_in;
  sq_t  stg [RootW];
  t1_t  t1, t1_next;
  t2_t  t2, t2_next;

  assign adv = !rsp.valid || rsp.ready;
  assign pop = adv && head_valid;

  always_comb begin
    stg_in.vld = head_valid;
    stg_in.tag = head;
    stg_in.rad = RadW'({head.frac, {ldas_pkg::RadShift{1'b0}}});
    stg_in.rem = '0;
    stg_in.root = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RootW; k++) begin
        stg[k].vld <= 1'b0;
      end
    end else if (adv) begin
      stg[0] <= sq_step(stg_in);
      for (int k = 1; k < RootW; k++) begin
        stg[k] <= sq_step(stg[k-1]);
      end
    end
  end

  // First tail stage: products from the root and the evaluation point.
  logic [31:0]        ax;
  logic signed [33:0] xp1;
  logic [32:0]        axp1;
  logic [29:0]        a_mag;
  logic [62:0]        pa_full;

  always_comb begin
    ax = stg[RootW-1].tag.x[31] ? 32'(~stg[RootW-1].tag.x + 32'sd1)
                                : 32'(stg[RootW-1].tag.x);
    xp1 = {{2{stg[RootW-1].tag.x[31]}}, stg[RootW-1].tag.x} + One34;
    axp1 = xp1[33] ? 33'(-xp1) : xp1[32:0];
    a_mag = law.intercept[29:0];
    pa_full = {33'd0, a_mag} * {30'd0, axp1};
    t1_next.vld = stg[RootW-1].vld;
    t1_next.tag = stg[RootW-1].tag;
    t1_next.root = stg[RootW-1].root;
    t1_next.xx_p = {32'd0, ax} * {32'd0, ax};
    t1_next.pa = pa_full[61:0];
    t1_next.pa_neg = xp1[33];
    t1_next.ps = {32'd0, a_mag} * {30'd0, ax};
    t1_next.ps_neg = !law.plus_pole ^ stg[RootW-1].tag.x[31];
    t1_next.sc_lo = {{(PrW - ScaleLoW){1'b0}}, law.scale[ScaleLoW-1:0]}
                  * {{(PrW - RootW){1'b0}}, stg[RootW-1].root};
    t1_next.sc_hi = {{(PrW - ScaleHiW){1'b0}}, law.scale[ScaleW-1:ScaleLoW]}
                  * {{(PrW - RootW){1'b0}}, stg[RootW-1].root};
  end

  // Second tail stage: density, first cumulative term, slope product, sample.
  logic signed [34:0] tq;
  logic [32:0]        mt;
  logic [SumW-1:0]    sum;
  logic [SumW-31:0]   p;
  logic [31:0]        pc;
  logic signed [33:0] term, pcs;

  always_comb begin
    tq = $signed({1'b0, t1.xx_p[63:30]}) - 35'(ldas_pkg::One);
    mt = tq[34] ? 33'(-tq) : tq[32:0];
    term = $signed({2'b00, t1.ps[61:30]});
    sum = SumW'({t1.sc_hi, {ScaleLoW{1'b0}}}) + SumW'(t1.sc_lo);
    p = sum[SumW-1:30];
    if (law.scale_sat) begin
      pc = (t1.root == '0) ? 32'd0 : 32'h8000_0000;
    end else if (p > (SumW-30)'(32'h8000_0000)) begin
      pc = 32'h8000_0000;
    end else begin
      pc = p[31:0];
    end
    pcs = $signed({2'b00, pc});
    t2_next.vld = t1.vld;
    t2_next.tag = t1.tag;
    t2_next.pdf = {{2{law.intercept[31]}}, law.intercept} + (t1.ps_neg ? -term : term);
    t2_next.c1 = t1.pa_neg ? -$signed({2'b00, t1.pa[61:30]}) : $signed({2'b00, t1.pa[61:30]});
    t2_next.pst = {33'd0, law.intercept[29:0]} * {30'd0, mt};
    t2_next.pst_neg = !law.plus_pole ^ tq[34];
    if (law.plus_pole) begin
      t2_next.smp = t1.tag.delta_hit ? ldas_pkg::One : 32'(pcs - One34);
    end else begin
      t2_next.smp = t1.tag.delta_hit ? -ldas_pkg::One : 32'(One34 - pcs);
    end
  end

  // Last stage: second cumulative term and selection by opcode.
  logic [32:0]        half;
  logic signed [35:0] c2, cdf;
  logic signed [31:0] value;
  logic               inf;

  always_comb begin
    half = {1'b0, t2.pst[62:31]};
    c2 = t2.pst_neg ? -$signed({3'b000, half}) : $signed({3'b000, half});
    cdf = 36'(t2.c1) + c2 + (law.plus_pole ? 36'sd0 : 36'(law.delta));
    value = 32'sd0;
    inf = 1'b0;
    unique case (t2.tag.op)
      ldas_pkg::OpDensity: begin
        if (t2.tag.pole_hit) begin
          value = 32'sh7FFF_FFFF;
          inf = 1'b1;
        end else begin
          value = sat32(36'(t2.pdf));
        end
      end
      ldas_pkg::OpCumulative: begin
        if (t2.tag.pole_hit) begin
          value = law.plus_pole ? ldas_pkg::One : 32'sd0;
        end else begin
          value = sat32(cdf);
        end
      end
      ldas_pkg::OpSample: value = t2.smp;
      default: value = 32'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.vld <= 1'b0;
      t2.vld <= 1'b0;
      rsp.valid <= 1'b0;
    end else if (adv) begin
      t1 <= t1_next;
      t2 <= t2_next;
      rsp.valid <= t2.vld;
      rsp.result_value <= value;
      rsp.is_infinite <= inf;
    end
  end

  a_inf_value: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.is_infinite) |-> (rsp.result_value == 32'sh7FFF_FFFF))
    else $error("infinite density without the largest value");

  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    (t2.vld && t2.tag.op == ldas_pkg::OpSample)
      |-> (t2.smp >= -ldas_pkg::One && t2.smp <= ldas_pkg::One))
    else $error("sample outside minus one to one");

  a_pop_head: assert property (@(posedge clk) disable iff (rst)
    (pop && !rsp.ready && rsp.valid) |-> 1'b0)
    else $error("queue popped while the output stalls");

endmodule

/* hw/rtl/linear_delta_angle_sampler.sv */
// Top level of the linear-plus-delta scattering-cosine sampler.
//
//   channel | role          | beat contents
//   --------+---------------+-------------------------------------------------
//   req     | request in    | opcode, cosine_point (Q2.30), uniform_fraction
//   rsp     | response out  | result_value (Q2.30), is_infinite
//   cfg     | register write| cfg_data = mean cosine (Q2.30), taken when cfg_we
//
// One request beat is taken per cycle while req.ready is high and each gives one
// response beat through the queue, the 31-stage square-root pipeline, two product
// stages and the output register. After reset, and after every write of the mean
// cosine, the derivation unit runs a 92-step divider and a 46-step square root;
// req.ready stays low until both end (neither runs for a zero intercept).
// A stalled response holds the whole back end; the queue (two entries by default)
// between the front and the back keeps taking beats until it fills.
module linear_delta_angle_sampler #(
  parameter int QUEUE_DEPTH = ldas_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic signed [31:0] cfg_data,
  ldas_req_if.sink           req,
  ldas_rsp_if.source         rsp
);

  // Coefficients of the law; intercept, slope and delta are held between configuration writes.
  ldas_pkg::law_t  law;
  // Head of the queue between the front and the back.
  ldas_pkg::item_t head;
  logic            head_valid;
  logic            pop;

  // Derives intercept, slope, delta weight and the sample scale sqrt(2/a).
  ldas_derive u_derive (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .law      (law)
  );

  // Classifies each request: pole hit, delta hit and the root operand.
  ldas_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .law        (law),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // Evaluates density, cumulative or sample and drives the response register.
  ldas_back u_back (
    .clk        (clk),
    .rst        (rst),
    .law        (law),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule
